/* rtl/core/acsc_pkg.sv */
// Shared types and constants for the ADC channel scan sequencer.
// No dependencies; every other file of the block imports this package.
package acsc_pkg;

	localparam int RAW_W   = 24;
	localparam int SCALE_W = 24;
	localparam int CH_W    = 3;
	localparam int CH_MAX  = 8;
	localparam int GAIN_W  = 3;
	localparam int CODE_W  = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INPUT_MODE  = 3'd0,
		CFG_SINGLE_MASK = 3'd1,
		CFG_DIFF_MASK   = 3'd2,
		CFG_GAIN_CODE   = 3'd3,
		CFG_SCALE_Q24   = 3'd4
	} cfg_index_t;

	localparam logic OP_START  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic MODE_SINGLE = 1'b0;
	localparam logic MODE_DIFF   = 1'b1;

	localparam logic [CH_MAX-1:0]  SINGLE_MASK_RST = 8'h41;
	localparam logic [3:0]         DIFF_MASK_RST   = 4'h1;
	localparam logic [GAIN_W-1:0]  GAIN_RST        = 3'd0;
	localparam logic [SCALE_W-1:0] SCALE_RST       = 24'd9648001;

	typedef struct packed {
		logic                     sample_valid;
		logic [CH_W-1:0]          sample_channel;
		logic signed [RAW_W-1:0]  raw_value;
		logic signed [RAW_W-1:0]  microvolts;
		logic                     mux_write;
		logic [CODE_W-1:0]        mux_code;
	} result_t;

	function automatic logic [CODE_W-1:0] single_code(input logic [CH_W-1:0] ch);
		return {1'b0, ch, 4'h8};
	endfunction

	function automatic logic [CODE_W-1:0] diff_code(input logic [CH_W-1:0] ch);
		return {ch, 1'b0, ch, 1'b1};
	endfunction

endpackage

/* rtl/core/acsc_if.sv */
// Valid/ready channel interfaces of the ADC channel scan sequencer.
// Depends on acsc_pkg for field widths.
interface acsc_in_if;
	import acsc_pkg::*;
	logic              valid;
	logic              ready;
	logic              operation;
	logic [RAW_W-1:0]  raw_sample;
	modport source (output valid, output operation, output raw_sample, input ready);
	modport sink (input valid, input operation, input raw_sample, output ready);
endinterface

interface acsc_out_if;
	import acsc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     sample_valid;
	logic [CH_W-1:0]          sample_channel;
	logic signed [RAW_W-1:0]  raw_value;
	logic signed [RAW_W-1:0]  microvolts;
	logic                     mux_write;
	logic [CODE_W-1:0]        mux_code;
	modport source (output valid, output sample_valid, output sample_channel,
		output raw_value, output microvolts, output mux_write, output mux_code,
		input ready);
	modport sink (input valid, input sample_valid, input sample_channel,
		input raw_value, input microvolts, input mux_write, input mux_code,
		output ready);
endinterface

interface acsc_cfg_if;
	import acsc_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [CFG_IDX_W-1:0]   index;
	logic [CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/adc_channel_scan_sequencer.sv */
// Top level of the ADC channel scan sequencer: configuration registers,
// channel selection and sample conversion. Depends on acsc_pkg and acsc_if.
//
// A word is captured in the input register when it is accepted, and its result
// is loaded into the output register once that register is free. A new word
// is accepted in every cycle while the output side keeps taking results.
// The input register feeds one stage of logic holding the 24 by 24 bit
// multiply and the priority pick of the next channel, whose result lands in
// the output register. A start word selects the lowest enabled channel; a
// sample word is tagged, converted to microvolts and, in single-ended mode,
// moves the scan to the next enabled channel. Configuration writes are taken
// in every cycle and should only be made while no word is in flight.
module adc_channel_scan_sequencer #(
	parameter int CHANNELS = 8
) (
	input logic clk,
	input logic arst_n,
	acsc_cfg_if.sink cfg,
	acsc_in_if.sink sample_in,
	acsc_out_if.source result_out
);
	import acsc_pkg::*;

	localparam logic [CH_MAX-1:0] ChMask  = CH_MAX'((1 << CHANNELS) - 1);
	localparam logic [CH_W-1:0]   LastCh  = CH_W'(CHANNELS - 1);

	function automatic logic [CH_W-1:0] lowest_set(input logic [CH_MAX-1:0] m);
		logic [CH_W-1:0] r;
		r = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = CH_W'(i);
			end
		end
		return r;
	endfunction

	logic                 input_mode_q;
	logic [CH_MAX-1:0]    single_mask_q;
	logic [3:0]           diff_mask_q;
	logic [GAIN_W-1:0]    gain_q;
	logic [SCALE_W-1:0]   scale_q;
	logic [CH_W-1:0]      current_channel_q;

	logic                 valid_s1;
	logic                 op_s1;
	logic [RAW_W-1:0]     raw_s1;
	logic [RAW_W-1:0]     mag_s1;
	logic                 neg_s1;

	logic                 out_valid_q;
	result_t              res_q;

	logic                 in_accept;
	logic                 out_load;
	logic                 s1_advance;

	logic [CH_MAX-1:0]    m_single;
	logic [CH_MAX-1:0]    m_diff;
	logic [CH_MAX-1:0]    above;
	logic [CH_MAX-1:0]    below;
	logic [CH_MAX-1:0]    hi_cand;
	logic [CH_MAX-1:0]    lo_cand;
	logic [2*RAW_W-1:0]   product;
	logic [RAW_W-1:0]     quot;
	logic [CH_W-1:0]      next_channel;
	result_t              res_d;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_mode_q  <= MODE_SINGLE;
			single_mask_q <= SINGLE_MASK_RST;
			diff_mask_q   <= DIFF_MASK_RST;
			gain_q        <= GAIN_RST;
			scale_q       <= SCALE_RST;
		end else if (cfg.valid) begin
			unique case (cfg_index_t'(cfg.index))
				CFG_INPUT_MODE:  input_mode_q  <= cfg.data[0];
				CFG_SINGLE_MASK: single_mask_q <= cfg.data[CH_MAX-1:0];
				CFG_DIFF_MASK:   diff_mask_q   <= cfg.data[3:0];
				CFG_GAIN_CODE:   gain_q        <= cfg.data[GAIN_W-1:0];
				CFG_SCALE_Q24:   scale_q       <= cfg.data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign out_load        = !out_valid_q || result_out.ready;
	assign s1_advance      = valid_s1 && out_load;
	assign sample_in.ready = !valid_s1 || out_load;
	assign in_accept       = sample_in.valid && sample_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_in.ready) begin
			valid_s1 <= sample_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1  <= sample_in.operation;
			raw_s1 <= sample_in.raw_sample;
			neg_s1 <= sample_in.raw_sample[RAW_W-1];
			mag_s1 <= sample_in.raw_sample[RAW_W-1] ? (RAW_W'(0) - sample_in.raw_sample)
				: sample_in.raw_sample;
		end
	end

	always_comb begin
		m_single = single_mask_q & ChMask;
		m_diff   = {4'b0, diff_mask_q} & ChMask;
		for (int i = 0; i < CH_MAX; i++) begin
			above[i] = CH_W'(i) > current_channel_q;
			below[i] = CH_W'(i) < current_channel_q;
		end
		hi_cand = (current_channel_q >= LastCh) ? m_single : (m_single & above);
		lo_cand = (current_channel_q >= LastCh) ? '0 : (m_single & below);

		product = {{RAW_W{1'b0}}, mag_s1} * {{RAW_W{1'b0}}, scale_q};
		quot    = product[2*RAW_W-1:RAW_W] >> gain_q;

		next_channel = current_channel_q;
		res_d = '0;
		if (op_s1 == OP_START) begin
			res_d.mux_write = 1'b1;
			if (input_mode_q == MODE_SINGLE) begin
				next_channel   = lowest_set(m_single);
				res_d.mux_code = single_code(next_channel);
			end else begin
				next_channel   = lowest_set(m_diff);
				res_d.mux_code = diff_code(next_channel);
			end
		end else begin
			res_d.sample_valid   = 1'b1;
			res_d.sample_channel = current_channel_q;
			res_d.raw_value      = raw_s1;
			res_d.microvolts     = neg_s1 ? (RAW_W'(0) - quot) : quot;
			if (input_mode_q == MODE_SINGLE) begin
				if (|hi_cand) begin
					next_channel    = lowest_set(hi_cand);
					res_d.mux_write = 1'b1;
					res_d.mux_code  = single_code(next_channel);
				end else if (|lo_cand) begin
					next_channel    = lowest_set(lo_cand);
					res_d.mux_write = 1'b1;
					res_d.mux_code  = single_code(next_channel);
				end
			end else begin
				res_d.mux_write = 1'b1;
				res_d.mux_code  = diff_code(current_channel_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_channel_q <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			if (s1_advance) begin
				current_channel_q <= next_channel;
			end
			if (out_load) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance) begin
			res_q <= res_d;
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.sample_valid   = res_q.sample_valid;
	assign result_out.sample_channel = res_q.sample_channel;
	assign result_out.raw_value      = res_q.raw_value;
	assign result_out.microvolts     = res_q.microvolts;
	assign result_out.mux_write      = res_q.mux_write;
	assign result_out.mux_code       = res_q.mux_code;

endmodule

/* tb/tb_top.sv */
// Self-checking bench for the ADC channel scan sequencer: start and sample words
// are checked against a channel scan and microvolt conversion kept in the bench.
// Depends on acsc_pkg, the channel interfaces in acsc_if and the sequencer top.
module tb_top;
	import acsc_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	logic clk;
	logic arst_n;

	acsc_cfg_if cfg_if();
	acsc_in_if  in_if();
	acsc_out_if out_if();

	adc_channel_scan_sequencer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.sample_in(in_if),
		.result_out(out_if)
	);

	logic              mode_q  = MODE_SINGLE;
	logic [CH_MAX-1:0] smask_q = SINGLE_MASK_RST;
	logic [3:0]        dmask_q = DIFF_MASK_RST;
	logic [GAIN_W-1:0] gain_q  = GAIN_RST;
	logic [SCALE_W-1:0] scale_q = SCALE_RST;
	logic [CH_W-1:0]   chan_q  = '0;

	result_t pending_results[$];
	int fault_count = 0;
	int cycle_count = 0;
	int gap_pct = 0;
	int stall_pct = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [CODE_W-1:0] mux_single(input logic [CH_W-1:0] ch);
		return {1'b0, ch, 4'h8};
	endfunction

	function automatic logic [CODE_W-1:0] mux_pair(input logic [CH_W-1:0] ch);
		return {ch, 1'b0, ch, 1'b1};
	endfunction

	function automatic result_t scan_step(input logic op, input logic [RAW_W-1:0] raw);
		result_t r;
		logic [63:0] mag;
		logic [63:0] prod;
		logic [RAW_W-1:0] q;
		logic [CH_MAX-1:0] en;
		logic [CH_W-1:0] nxt;
		logic found;
		int i;
		int first;
		r = '0;
		nxt = '0;
		found = 1'b0;
		if (op == OP_START) begin
			en = (mode_q == MODE_SINGLE) ? smask_q : {4'b0, dmask_q};
			for (i = CH_MAX - 1; i >= 0; i--)
				if (en[i])
					nxt = 3'(i);
			chan_q = nxt;
			r.mux_write = 1'b1;
			r.mux_code = (mode_q == MODE_SINGLE) ? mux_single(chan_q) : mux_pair(chan_q);
			return r;
		end
		r.sample_valid = 1'b1;
		r.sample_channel = chan_q;
		r.raw_value = raw;
		mag = raw[RAW_W-1] ? (64'h1000000 - 64'(raw)) : 64'(raw);
		prod = (mag * 64'(scale_q)) >> (24 + gain_q);
		q = prod[RAW_W-1:0];
		r.microvolts = raw[RAW_W-1] ? -q : q;
		if (mode_q == MODE_SINGLE) begin
			first = (chan_q >= CH_MAX - 1) ? 0 : int'(chan_q) + 1;
			for (i = first; i < CH_MAX; i++)
				if (!found && smask_q[i]) begin
					nxt = 3'(i);
					found = 1'b1;
				end
			for (i = 0; i < int'(chan_q); i++)
				if (!found && smask_q[i]) begin
					nxt = 3'(i);
					found = 1'b1;
				end
			if (found)
				chan_q = nxt;
			r.mux_write = found;
			r.mux_code = found ? mux_single(nxt) : '0;
		end else begin
			r.mux_write = 1'b1;
			r.mux_code = mux_pair(chan_q);
		end
		return r;
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw();
		case ($urandom_range(9))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return ($urandom_range(1) == 0) ? 24'h000000 : 24'hFFFFFF;
			3: return 24'(($urandom_range(1) == 0) ? 1 : 24'h800001);
			default: return 24'($urandom());
		endcase
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	always @(posedge clk)
		out_if.ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (pending_results.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected result word: ch=%0d raw=%0d uv=%0d code=%02h",
						out_if.sample_channel, out_if.raw_value, out_if.microvolts,
						out_if.mux_code);
			end else begin
				want = pending_results.pop_front();
				if (out_if.sample_valid !== want.sample_valid
						|| out_if.sample_channel !== want.sample_channel
						|| out_if.raw_value !== want.raw_value
						|| out_if.microvolts !== want.microvolts
						|| out_if.mux_write !== want.mux_write
						|| out_if.mux_code !== want.mux_code) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("mismatch got:  sv=%0b ch=%0d raw=%0d uv=%0d mw=%0b code=%02h",
							out_if.sample_valid, out_if.sample_channel, out_if.raw_value,
							out_if.microvolts, out_if.mux_write, out_if.mux_code);
						$display("mismatch want: sv=%0b ch=%0d raw=%0d uv=%0d mw=%0b code=%02h",
							want.sample_valid, want.sample_channel, want.raw_value,
							want.microvolts, want.mux_write, want.mux_code);
					end
				end
			end
		end
	end

	task automatic cfg_write(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		case (idx)
			CFG_INPUT_MODE:  mode_q = value[0];
			CFG_SINGLE_MASK: smask_q = value[CH_MAX-1:0];
			CFG_DIFF_MASK:   dmask_q = value[3:0];
			CFG_GAIN_CODE:   gain_q = value[GAIN_W-1:0];
			CFG_SCALE_Q24:   scale_q = value[SCALE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic mode, input logic [7:0] smask,
			input logic [3:0] dmask, input logic [2:0] gain, input logic [23:0] scale);
		cfg_write(CFG_INPUT_MODE, 24'(mode));
		cfg_write(CFG_SINGLE_MASK, 24'(smask));
		cfg_write(CFG_DIFF_MASK, 24'(dmask));
		cfg_write(CFG_GAIN_CODE, 24'(gain));
		cfg_write(CFG_SCALE_Q24, scale);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic send_word(input logic op, input logic [RAW_W-1:0] raw);
		while ($urandom_range(99) < gap_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.operation <= op;
		in_if.raw_sample <= raw;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		pending_results.push_back(scan_step(op, raw));
	endtask

	task automatic settle();
		in_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic test_reset_defaults();
		send_word(OP_START, 24'h000000);
		send_word(OP_SAMPLE, 24'h7FFFFF);
		send_word(OP_SAMPLE, 24'h800000);
		send_word(OP_SAMPLE, 24'hFFFFFF);
		send_word(OP_SAMPLE, 24'h000000);
		settle();
	endtask

	task automatic test_single_search();
		set_config(MODE_SINGLE, 8'h80, 4'h0, 3'd7, 24'hFFFFFF);
		send_word(OP_START, 24'h000000);
		send_word(OP_SAMPLE, 24'h800000);
		send_word(OP_SAMPLE, 24'h7FFFFF);
		settle();
		set_config(MODE_SINGLE, 8'h10, 4'h0, 3'd0, 24'hFFFFFF);
		send_word(OP_START, 24'h000000);
		send_word(OP_SAMPLE, 24'hFFFFFF);
		send_word(OP_SAMPLE, 24'h000001);
		settle();
	endtask

	task automatic test_empty_masks();
		set_config(MODE_SINGLE, 8'h00, 4'h0, 3'd3, 24'h000000);
		send_word(OP_START, 24'h123456);
		send_word(OP_SAMPLE, 24'h800001);
		settle();
		set_config(MODE_DIFF, 8'h00, 4'h0, 3'd3, SCALE_RST);
		send_word(OP_START, 24'h000000);
		send_word(OP_SAMPLE, 24'h400000);
		settle();
	endtask

	task automatic test_diff_pairs();
		set_config(MODE_DIFF, 8'hFF, 4'h8, 3'd6, SCALE_RST);
		send_word(OP_START, 24'h000000);
		send_word(OP_SAMPLE, 24'hC00000);
		settle();
	endtask

	task automatic test_mode_switch();
		set_config(MODE_SINGLE, 8'hFF, 4'hF, 3'd1, 24'hABCDEF);
		send_word(OP_SAMPLE, 24'h7FFFFF);
		settle();
		set_config(MODE_DIFF, 8'hFF, 4'hF, 3'd2, 24'hABCDEF);
		send_word(OP_SAMPLE, 24'h800000);
		settle();
		set_config(MODE_SINGLE, 8'h80, 4'hF, 3'd0, SCALE_RST);
		send_word(OP_START, 24'h000000);
		settle();
		set_config(MODE_DIFF, 8'h80, 4'h1, 3'd0, SCALE_RST);
		send_word(OP_SAMPLE, 24'hFFFFFF);
		settle();
	endtask

	task automatic test_random_scan();
		logic [7:0] smask;
		logic [3:0] dmask;
		logic [23:0] scale;
		int phase;
		int seg;
		int n;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 45; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 45; end
				default: begin gap_pct = 15; stall_pct = 15; end
			endcase
			for (seg = 0; seg < 5; seg++) begin
				settle();
				case ($urandom_range(4))
					0: smask = 8'h00;
					1: smask = 8'hFF;
					2: smask = 8'(1 << $urandom_range(7));
					default: smask = 8'($urandom());
				endcase
				case ($urandom_range(3))
					0: dmask = 4'h0;
					1: dmask = 4'hF;
					default: dmask = 4'($urandom());
				endcase
				case ($urandom_range(4))
					0: scale = 24'h000000;
					1: scale = 24'hFFFFFF;
					2: scale = SCALE_RST;
					default: scale = 24'($urandom());
				endcase
				set_config(1'($urandom_range(1)), smask, dmask, 3'($urandom_range(7)), scale);
				if ($urandom_range(9) < 7)
					send_word(OP_START, pick_raw());
				for (n = 0; n < 88; n++) begin
					if (n == 40 && seg == 0)
						settle();
					send_word(($urandom_range(99) < 8) ? OP_START : OP_SAMPLE, pick_raw());
				end
			end
		end
		gap_pct = 0;
		stall_pct = 0;
		settle();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_if.valid <= 1'b0;
		in_if.operation <= OP_START;
		in_if.raw_sample <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= CFG_INPUT_MODE;
		cfg_if.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_single_search();
		test_empty_masks();
		test_diff_pairs();
		test_mode_switch();
		test_random_scan();
		repeat (8) @(posedge clk);
		if (fault_count == 0 && pending_results.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
